>>> rtl/grouped_inverse_variance_merge_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grouped inverse-variance merge block
// Shared shorthands for the concurrent checks; clocked on clk, off in rst.
// ----------------------------------------------------------------------------
`ifndef GROUPED_INVERSE_VARIANCE_MERGE_ASSERT_SVH
`define GROUPED_INVERSE_VARIANCE_MERGE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GIVM_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("givm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define GIVM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("givm assertion failed");

`endif

>>> rtl/givm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// givm_pkg
// Types, codes and constants shared by the merge controller and datapath.
// ----------------------------------------------------------------------------
package givm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ACC_BITS_DEF  = 64;

  // Divider divisor and quotient width, also the base of the numerator width; multiplier operand width.
  localparam int NUM_W = 64;
  localparam int MUL_W = 32;

  localparam logic [30:0] ERR_MAX      = 31'h7FFF_FFFF;
  localparam logic [63:0] MEAN_POS_SAT = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] MEAN_NEG_SAT = 64'h0000_0000_8000_0000;
  localparam logic [63:0] SQRT_BIT0    = 64'h4000_0000_0000_0000;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_VEL_FLOOR = 2'd0;
  localparam logic [1:0] REG_PWR_FLOOR = 2'd1;
  localparam logic [1:0] REG_WDT_FLOOR = 2'd2;

  // Measurement channels.
  localparam logic [1:0] CH_VEL  = 2'd0;
  localparam logic [1:0] CH_PWR  = 2'd1;
  localparam logic [1:0] CH_WDT  = 2'd2;
  localparam int         NUM_CH  = 3;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_OPEN, S_SQ, S_DIVW_GO, S_DIVW_WAIT, S_MUL_LO, S_MUL_HI,
    S_MUL_ADD, S_ACCUM, S_AZ_GO, S_AZ_WAIT, S_FIN_CHK, S_MEAN_GO, S_MEAN_WAIT,
    S_ERR_GO, S_ERR_WAIT, S_SQRT_WAIT, S_EMIT
  } state_t;

  typedef enum logic [1:0] {MUL_SQ, MUL_LO, MUL_HI} mul_op_t;

  typedef enum logic [1:0] {DIV_WEIGHT, DIV_MEAN, DIV_ERR, DIV_AZ} div_src_t;

  typedef struct packed {
    logic       latch_in;
    logic       open_group;
    logic       az_update;
    logic       mul_en;
    mul_op_t    mul_op;
    logic       w_load;
    logic       pacc_load;
    logic       pacc_add;
    logic       accum;
    logic       div_start;
    div_src_t   div_src;
    logic       fin_az;
    logic       fin_zero;
    logic       fin_mean;
    logic       sqrt_start;
    logic       fin_err;
    logic       load_out;
    logic       out_last;
    logic       close_group;
    logic [1:0] chan;
  } dp_cmd_t;

  typedef struct packed {
    logic key_diff;
    logic group_open;
    logic in_last;
    logic div_done;
    logic div_busy;
    logic sqrt_done;
    logic ws_zero;
    logic out_hold;
  } dp_sts_t;

endpackage

>>> rtl/givm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// givm_div
// Restoring divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
module givm_div #(
  parameter int XW = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [XW-1:0] x,
  input  logic [63:0]   d,
  input  logic [63:0]   sat,
  output logic          busy,
  output logic          done,
  output logic [63:0]   q
);

  localparam int CW = $clog2(XW + 1);

  logic [XW-1:0] xs;
  logic [63:0]   rem;
  logic [63:0]   qr;
  logic          over;
  logic [CW-1:0] cnt;
  logic [63:0]   d_r;
  logic [63:0]   sat_r;

  logic [64:0] rs;
  logic [64:0] rdiff;
  logic        ge;

  assign rs    = {rem, xs[XW-1]};
  assign ge    = rs >= {1'b0, d_r};
  assign rdiff = rs - {1'b0, d_r};

  // A quotient that runs past 64 bits or past the limit saturates, as does a zero divisor.
  assign q = (over || (d_r == 64'd0) || (qr > sat_r)) ? sat_r : qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CW'(1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs    <= x;
      rem   <= 64'd0;
      qr    <= 64'd0;
      over  <= 1'b0;
      cnt   <= CW'(XW);
      d_r   <= d;
      sat_r <= sat;
    end else if (busy) begin
      xs   <= xs << 1;
      rem  <= ge ? rdiff[63:0] : rs[63:0];
      qr   <= {qr[62:0], ge};
      over <= over | qr[63];
      cnt  <= cnt - CW'(1);
    end
  end

endmodule

>>> rtl/givm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// givm_dp
// Merge datapath: group state, shared multiplier, divider, square root.
// ----------------------------------------------------------------------------
module givm_dp #(
  parameter int FRAC_BITS = givm_pkg::FRAC_BITS_DEF,
  parameter int ACC_BITS  = givm_pkg::ACC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  givm_pkg::dp_cmd_t    cmd,
  output givm_pkg::dp_sts_t    sts,
  input  logic [2:0][30:0]     floors,
  input  logic [15:0]          in_station,
  input  logic [23:0]          in_cell,
  input  logic signed [24:0]   in_azimuth,
  input  logic signed [23:0]   in_lat,
  input  logic signed [25:0]   in_lon,
  input  logic signed [31:0]   in_vel,
  input  logic [30:0]          in_vel_err,
  input  logic signed [31:0]   in_pwr,
  input  logic [30:0]          in_pwr_err,
  input  logic signed [31:0]   in_wdt,
  input  logic [30:0]          in_wdt_err,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_station,
  output logic [23:0]          out_cell,
  output logic signed [24:0]   out_azimuth,
  output logic signed [23:0]   out_lat,
  output logic signed [25:0]   out_lon,
  output logic signed [31:0]   out_vel,
  output logic [30:0]          out_vel_err,
  output logic signed [31:0]   out_pwr,
  output logic [30:0]          out_pwr_err,
  output logic signed [31:0]   out_wdt,
  output logic [30:0]          out_wdt_err,
  output logic                 out_last
);

  localparam int XW = givm_pkg::NUM_W + 4 * FRAC_BITS;
  localparam int PW = 3 * givm_pkg::MUL_W;
  localparam logic [ACC_BITS-1:0] AMAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS:0] AMAX_S = {2'b00, {(ACC_BITS-1){1'b1}}};

  // Latched input item.
  logic [15:0]        cur_station;
  logic [23:0]        cur_cell;
  logic [24:0]        cur_az;
  logic [23:0]        cur_lat;
  logic [25:0]        cur_lon;
  logic [31:0]        cur_val [givm_pkg::NUM_CH];
  logic [30:0]        cur_err [givm_pkg::NUM_CH];
  logic               cur_last;

  // Group state.
  logic               grp_open;
  logic [15:0]        grp_station;
  logic [23:0]        grp_cell;
  logic [15:0]        grp_count;
  logic signed [47:0] az_sum;
  logic [23:0]        first_lat;
  logic [25:0]        first_lon;
  logic [ACC_BITS-1:0] wsum [givm_pkg::NUM_CH];
  logic [ACC_BITS-1:0] wgt  [givm_pkg::NUM_CH];

  // Arithmetic registers.
  logic [63:0]         prod;
  logic [ACC_BITS-1:0] w_reg;
  logic [PW-1:0]       pacc;
  logic [63:0]         sq_x;
  logic [63:0]         sq_res;
  logic [63:0]         sq_bit;
  logic                sq_busy;
  logic                sq_done;

  // Finished group values.
  logic [24:0]         fin_az;
  logic [31:0]         fin_mean [givm_pkg::NUM_CH];
  logic [30:0]         fin_err  [givm_pkg::NUM_CH];

  logic [31:0]         x_sel;
  logic [31:0]         x_abs;
  logic [30:0]         e_raw;
  logic [30:0]         e_max;
  logic [30:0]         e_eff;
  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [63:0]         w_wide;
  logic [PW-1:0]       pshift;
  logic [ACC_BITS-1:0] mag;
  logic [ACC_BITS-1:0] term;
  logic [ACC_BITS-1:0] wsum_c;
  logic [ACC_BITS-1:0] wgt_c;
  logic signed [ACC_BITS:0] s_sum;
  logic [ACC_BITS-1:0] wsum_n;
  logic [ACC_BITS:0]   ws_sum;
  logic [ACC_BITS-1:0] wgt_n;
  logic                wsum_neg;
  logic [ACC_BITS-1:0] wsum_abs;
  logic                az_neg;
  logic [47:0]         az_abs;
  logic [47:0]         az_mean;
  logic [XW-1:0]       div_x;
  logic [63:0]         div_d;
  logic [63:0]         div_sat;
  logic [63:0]         div_q;
  logic                div_busy;
  logic                div_done;
  logic [63:0]         sq_try;
  logic [31:0]         mean_q;

  assign x_sel = cur_val[cmd.chan];
  assign e_raw = cur_err[cmd.chan];
  assign e_max = (e_raw < floors[cmd.chan]) ? floors[cmd.chan] : e_raw;
  assign e_eff = (e_max == 31'd0) ? 31'd1 : e_max;
  assign x_abs = x_sel[31] ? (~x_sel + 32'd1) : x_sel;
  assign w_wide = 64'(w_reg);

  always_comb begin
    case (cmd.mul_op)
      givm_pkg::MUL_LO: begin
        mul_a = x_abs;
        mul_b = w_wide[31:0];
      end
      givm_pkg::MUL_HI: begin
        mul_a = x_abs;
        mul_b = w_wide[63:32];
      end
      default: begin
        mul_a = {1'b0, e_eff};
        mul_b = {1'b0, e_eff};
      end
    endcase
  end

  // Term = sign(x) * min(|x| * W >> F, AMAX), then saturating accumulation.
  assign pshift = pacc >> FRAC_BITS;
  assign mag    = (pshift > PW'(AMAX)) ? AMAX : pshift[ACC_BITS-1:0];
  assign term   = x_sel[31] ? (~mag + ACC_BITS'(1)) : mag;
  assign wsum_c = wsum[cmd.chan];
  assign wgt_c  = wgt[cmd.chan];
  assign s_sum  = $signed({wsum_c[ACC_BITS-1], wsum_c}) + $signed({term[ACC_BITS-1], term});

  always_comb begin
    if (s_sum > AMAX_S) begin
      wsum_n = AMAX;
    end else if (s_sum < -AMAX_S) begin
      wsum_n = ~AMAX + ACC_BITS'(1);
    end else begin
      wsum_n = s_sum[ACC_BITS-1:0];
    end
  end

  assign ws_sum = {1'b0, wgt_c} + {1'b0, w_reg};
  assign wgt_n  = (ws_sum > {1'b0, AMAX}) ? AMAX : ws_sum[ACC_BITS-1:0];

  assign wsum_neg = wsum_c[ACC_BITS-1];
  assign wsum_abs = wsum_neg ? (~wsum_c + ACC_BITS'(1)) : wsum_c;
  assign az_neg   = az_sum[47];
  assign az_abs   = az_neg ? (~az_sum + 48'd1) : az_sum;

  always_comb begin
    case (cmd.div_src)
      givm_pkg::DIV_MEAN: begin
        div_x   = XW'(wsum_abs) << FRAC_BITS;
        div_d   = 64'(wgt_c);
        div_sat = wsum_neg ? givm_pkg::MEAN_NEG_SAT : givm_pkg::MEAN_POS_SAT;
      end
      givm_pkg::DIV_ERR: begin
        div_x   = XW'(1) << (4 * FRAC_BITS);
        div_d   = 64'(wgt_c);
        div_sat = '1;
      end
      givm_pkg::DIV_AZ: begin
        div_x   = XW'(az_abs);
        div_d   = 64'(grp_count);
        div_sat = '1;
      end
      default: begin
        div_x   = XW'(1) << (4 * FRAC_BITS);
        div_d   = prod;
        div_sat = 64'(AMAX);
      end
    endcase
  end

  givm_div #(
    .XW (XW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .x     (div_x),
    .d     (div_d),
    .sat   (div_sat),
    .busy  (div_busy),
    .done  (div_done),
    .q     (div_q)
  );

  assign az_mean = az_neg ? (~div_q[47:0] + 48'd1) : div_q[47:0];
  assign mean_q  = div_q[31:0];
  assign sq_try  = sq_res + sq_bit;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_open  <= 1'b0;
      out_valid <= 1'b0;
      sq_busy   <= 1'b0;
      sq_done   <= 1'b0;
    end else begin
      if (cmd.open_group) begin
        grp_open <= 1'b1;
      end else if (cmd.close_group) begin
        grp_open <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      sq_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_busy <= 1'b1;
      end else if (sq_busy && sq_bit[0]) begin
        sq_busy <= 1'b0;
        sq_done <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cur_station <= in_station;
      cur_cell    <= in_cell;
      cur_az      <= in_azimuth;
      cur_lat     <= in_lat;
      cur_lon     <= in_lon;
      cur_val[givm_pkg::CH_VEL] <= in_vel;
      cur_val[givm_pkg::CH_PWR] <= in_pwr;
      cur_val[givm_pkg::CH_WDT] <= in_wdt;
      cur_err[givm_pkg::CH_VEL] <= in_vel_err;
      cur_err[givm_pkg::CH_PWR] <= in_pwr_err;
      cur_err[givm_pkg::CH_WDT] <= in_wdt_err;
      cur_last    <= in_last;
    end

    if (cmd.open_group) begin
      grp_station <= cur_station;
      grp_cell    <= cur_cell;
      first_lat   <= cur_lat;
      first_lon   <= cur_lon;
      for (int k = 0; k < givm_pkg::NUM_CH; k++) begin
        wsum[k] <= '0;
        wgt[k]  <= '0;
      end
    end else if (cmd.accum) begin
      wsum[cmd.chan] <= wsum_n;
      wgt[cmd.chan]  <= wgt_n;
    end

    // The count and azimuth sum stop once the count saturates.
    if (cmd.az_update) begin
      if (cmd.open_group) begin
        az_sum    <= 48'(signed'(cur_az));
        grp_count <= 16'd1;
      end else if (grp_count != 16'hFFFF) begin
        az_sum    <= az_sum + 48'(signed'(cur_az));
        grp_count <= grp_count + 16'd1;
      end
    end

    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.w_load) begin
      w_reg <= div_q[ACC_BITS-1:0];
    end
    if (cmd.pacc_load) begin
      pacc <= PW'(prod);
    end else if (cmd.pacc_add) begin
      pacc <= pacc + {prod, 32'd0};
    end

    if (cmd.sqrt_start) begin
      sq_x   <= div_q;
      sq_res <= 64'd0;
      sq_bit <= givm_pkg::SQRT_BIT0;
    end else if (sq_busy) begin
      if (sq_x >= sq_try) begin
        sq_x   <= sq_x - sq_try;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end

    if (cmd.fin_az) begin
      fin_az <= az_mean[24:0];
    end
    if (cmd.fin_zero) begin
      fin_mean[cmd.chan] <= 32'd0;
      fin_err[cmd.chan]  <= givm_pkg::ERR_MAX;
    end else if (cmd.fin_mean) begin
      fin_mean[cmd.chan] <= wsum_neg ? (~mean_q + 32'd1) : mean_q;
    end
    if (cmd.fin_err) begin
      fin_err[cmd.chan] <= (sq_res > 64'(givm_pkg::ERR_MAX)) ? givm_pkg::ERR_MAX
                                                              : sq_res[30:0];
    end

    if (cmd.load_out) begin
      out_station <= grp_station;
      out_cell    <= grp_cell;
      out_azimuth <= fin_az;
      out_lat     <= first_lat;
      out_lon     <= first_lon;
      out_vel     <= fin_mean[givm_pkg::CH_VEL];
      out_vel_err <= fin_err[givm_pkg::CH_VEL];
      out_pwr     <= fin_mean[givm_pkg::CH_PWR];
      out_pwr_err <= fin_err[givm_pkg::CH_PWR];
      out_wdt     <= fin_mean[givm_pkg::CH_WDT];
      out_wdt_err <= fin_err[givm_pkg::CH_WDT];
      out_last    <= cmd.out_last;
    end
  end

  always_comb begin
    sts.key_diff   = (cur_station != grp_station) || (cur_cell != grp_cell);
    sts.group_open = grp_open;
    sts.in_last    = cur_last;
    sts.div_done   = div_done;
    sts.div_busy   = div_busy;
    sts.sqrt_done  = sq_done;
    sts.ws_zero    = (wgt_c == '0);
    sts.out_hold   = out_valid && out_stall;
  end

endmodule

>>> rtl/givm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// givm_ctrl
// Sequencer for per-vector accumulation and per-group finishing.
// ----------------------------------------------------------------------------
module givm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output givm_pkg::dp_cmd_t cmd,
  input  givm_pkg::dp_sts_t sts
);

  localparam logic [1:0] LAST_CH = 2'(givm_pkg::NUM_CH - 1);

  givm_pkg::state_t state, state_next;
  logic [1:0] chan, chan_next;
  logic       emit_last, emit_last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= givm_pkg::S_IDLE;
      chan      <= givm_pkg::CH_VEL;
      emit_last <= 1'b0;
    end else begin
      state     <= state_next;
      chan      <= chan_next;
      emit_last <= emit_last_next;
    end
  end

  always_comb begin
    state_next     = state;
    chan_next      = chan;
    emit_last_next = emit_last;
    case (state)
      givm_pkg::S_IDLE: begin
        if (in_valid) state_next = givm_pkg::S_CHECK;
      end
      givm_pkg::S_CHECK: begin
        if (sts.group_open && sts.key_diff) begin
          emit_last_next = 1'b0;
          state_next     = givm_pkg::S_AZ_GO;
        end else begin
          state_next = givm_pkg::S_OPEN;
        end
      end
      givm_pkg::S_OPEN: begin
        chan_next  = givm_pkg::CH_VEL;
        state_next = givm_pkg::S_SQ;
      end
      givm_pkg::S_SQ:        state_next = givm_pkg::S_DIVW_GO;
      givm_pkg::S_DIVW_GO:   state_next = givm_pkg::S_DIVW_WAIT;
      givm_pkg::S_DIVW_WAIT: begin
        if (sts.div_done) state_next = givm_pkg::S_MUL_LO;
      end
      givm_pkg::S_MUL_LO:    state_next = givm_pkg::S_MUL_HI;
      givm_pkg::S_MUL_HI:    state_next = givm_pkg::S_MUL_ADD;
      givm_pkg::S_MUL_ADD:   state_next = givm_pkg::S_ACCUM;
      givm_pkg::S_ACCUM: begin
        if (chan != LAST_CH) begin
          chan_next  = chan + 2'd1;
          state_next = givm_pkg::S_SQ;
        end else if (sts.in_last) begin
          emit_last_next = 1'b1;
          state_next     = givm_pkg::S_AZ_GO;
        end else begin
          state_next = givm_pkg::S_IDLE;
        end
      end
      givm_pkg::S_AZ_GO:     state_next = givm_pkg::S_AZ_WAIT;
      givm_pkg::S_AZ_WAIT: begin
        if (sts.div_done) begin
          chan_next  = givm_pkg::CH_VEL;
          state_next = givm_pkg::S_FIN_CHK;
        end
      end
      givm_pkg::S_FIN_CHK: begin
        if (!sts.ws_zero) begin
          state_next = givm_pkg::S_MEAN_GO;
        end else if (chan != LAST_CH) begin
          chan_next = chan + 2'd1;
        end else begin
          state_next = givm_pkg::S_EMIT;
        end
      end
      givm_pkg::S_MEAN_GO:   state_next = givm_pkg::S_MEAN_WAIT;
      givm_pkg::S_MEAN_WAIT: begin
        if (sts.div_done) state_next = givm_pkg::S_ERR_GO;
      end
      givm_pkg::S_ERR_GO:    state_next = givm_pkg::S_ERR_WAIT;
      givm_pkg::S_ERR_WAIT: begin
        if (sts.div_done) state_next = givm_pkg::S_SQRT_WAIT;
      end
      givm_pkg::S_SQRT_WAIT: begin
        if (sts.sqrt_done) begin
          if (chan != LAST_CH) begin
            chan_next  = chan + 2'd1;
            state_next = givm_pkg::S_FIN_CHK;
          end else begin
            state_next = givm_pkg::S_EMIT;
          end
        end
      end
      givm_pkg::S_EMIT: begin
        if (!sts.out_hold) begin
          state_next = emit_last ? givm_pkg::S_IDLE : givm_pkg::S_OPEN;
        end
      end
      default: state_next = givm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.chan = chan;
    in_stall = 1'b1;
    case (state)
      givm_pkg::S_IDLE: begin
        in_stall     = 1'b0;
        cmd.latch_in = in_valid;
      end
      givm_pkg::S_OPEN: begin
        cmd.open_group = !sts.group_open;
        cmd.az_update  = 1'b1;
      end
      givm_pkg::S_SQ: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = givm_pkg::MUL_SQ;
      end
      givm_pkg::S_DIVW_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = givm_pkg::DIV_WEIGHT;
      end
      givm_pkg::S_DIVW_WAIT: begin
        cmd.w_load = sts.div_done;
      end
      givm_pkg::S_MUL_LO: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = givm_pkg::MUL_LO;
      end
      givm_pkg::S_MUL_HI: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_op    = givm_pkg::MUL_HI;
        cmd.pacc_load = 1'b1;
      end
      givm_pkg::S_MUL_ADD: begin
        cmd.pacc_add = 1'b1;
      end
      givm_pkg::S_ACCUM: begin
        cmd.accum = 1'b1;
      end
      givm_pkg::S_AZ_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = givm_pkg::DIV_AZ;
      end
      givm_pkg::S_AZ_WAIT: begin
        cmd.div_src = givm_pkg::DIV_AZ;
        cmd.fin_az  = sts.div_done;
      end
      givm_pkg::S_FIN_CHK: begin
        cmd.fin_zero = sts.ws_zero;
      end
      givm_pkg::S_MEAN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = givm_pkg::DIV_MEAN;
      end
      givm_pkg::S_MEAN_WAIT: begin
        cmd.div_src  = givm_pkg::DIV_MEAN;
        cmd.fin_mean = sts.div_done;
      end
      givm_pkg::S_ERR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = givm_pkg::DIV_ERR;
      end
      givm_pkg::S_ERR_WAIT: begin
        cmd.div_src    = givm_pkg::DIV_ERR;
        cmd.sqrt_start = sts.div_done;
      end
      givm_pkg::S_SQRT_WAIT: begin
        cmd.fin_err = sts.sqrt_done;
      end
      givm_pkg::S_EMIT: begin
        cmd.load_out    = !sts.out_hold;
        cmd.close_group = !sts.out_hold;
        cmd.out_last    = emit_last;
      end
      default: begin
        cmd.chan = chan;
      end
    endcase
  end

endmodule

>>> rtl/grouped_inverse_variance_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_inverse_variance_merge
// Merges runs of sorted grid vectors with equal station and cell into one
// inverse-variance weighted result per run.
// ----------------------------------------------------------------------------
// The block takes one vector transaction at a time and holds in_stall high
// while it works on it. Each vector is folded into the open group by three
// channel passes (velocity, power, width); every pass squares the floored
// error on a shared 32x32 multiplier, forms the weight 2^(4F)/e^2 on a
// restoring divider that retires one quotient bit per cycle over
// 64 + 4*FRAC_BITS bits, and scales the value by the low and high halves
// of the weight on the same multiplier. Closing a group (on a key change,
// before the new vector is folded in, or after a vector marked in_last) adds
// one divider run for the azimuth mean and, for each channel with a nonzero
// weight sum, a divider run for the mean, one for 2^(4F)/weight and a
// 32-step square root, so at most 7 divider runs in all. Results leave
// through an output register, so a new vector is accepted while the last
// result still waits on out_stall; a second result of the same vector
// waits for that register to free up. The error floors are written through
// the APB-style port (velocity at 0x0, power at 0x4, width at 0x8); the
// user must write them only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module grouped_inverse_variance_merge #(
  parameter int FRAC_BITS = givm_pkg::FRAC_BITS_DEF,
  parameter int ACC_BITS  = givm_pkg::ACC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // Input vector transactions.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_station,
  input  logic [23:0]        in_cell,
  input  logic signed [24:0] in_azimuth,
  input  logic signed [23:0] in_lat,
  input  logic signed [25:0] in_lon,
  input  logic signed [31:0] in_vel,
  input  logic [30:0]        in_vel_err,
  input  logic signed [31:0] in_pwr,
  input  logic [30:0]        in_pwr_err,
  input  logic signed [31:0] in_wdt,
  input  logic [30:0]        in_wdt_err,
  input  logic               in_last,
  // Merged group transactions.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_station,
  output logic [23:0]        out_cell,
  output logic signed [24:0] out_azimuth,
  output logic signed [23:0] out_lat,
  output logic signed [25:0] out_lon,
  output logic signed [31:0] out_vel,
  output logic [30:0]        out_vel_err,
  output logic signed [31:0] out_pwr,
  output logic [30:0]        out_pwr_err,
  output logic signed [31:0] out_wdt,
  output logic [30:0]        out_wdt_err,
  output logic               out_last,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  `include "grouped_inverse_variance_merge_assert.svh"

  // An error floor of 1.0 in the chosen fixed-point format.
  localparam logic [30:0] FLOOR_RST = 31'(64'd1 << FRAC_BITS);

  logic [2:0][30:0]  floors;
  logic              cfg_wr;
  givm_pkg::dp_cmd_t cmd;
  givm_pkg::dp_sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Writes to the unused fourth word are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      floors <= {3{FLOOR_RST}};
    end else if (cfg_wr) begin
      case (paddr[3:2])
        givm_pkg::REG_VEL_FLOOR: floors[givm_pkg::CH_VEL] <= pwdata[30:0];
        givm_pkg::REG_PWR_FLOOR: floors[givm_pkg::CH_PWR] <= pwdata[30:0];
        givm_pkg::REG_WDT_FLOOR: floors[givm_pkg::CH_WDT] <= pwdata[30:0];
        default: floors <= floors;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      givm_pkg::REG_VEL_FLOOR: prdata = {1'b0, floors[givm_pkg::CH_VEL]};
      givm_pkg::REG_PWR_FLOOR: prdata = {1'b0, floors[givm_pkg::CH_PWR]};
      givm_pkg::REG_WDT_FLOOR: prdata = {1'b0, floors[givm_pkg::CH_WDT]};
      default:                 prdata = 32'd0;
    endcase
  end

  givm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  givm_dp #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_BITS  (ACC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .floors      (floors),
    .in_station  (in_station),
    .in_cell     (in_cell),
    .in_azimuth  (in_azimuth),
    .in_lat      (in_lat),
    .in_lon      (in_lon),
    .in_vel      (in_vel),
    .in_vel_err  (in_vel_err),
    .in_pwr      (in_pwr),
    .in_pwr_err  (in_pwr_err),
    .in_wdt      (in_wdt),
    .in_wdt_err  (in_wdt_err),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_station (out_station),
    .out_cell    (out_cell),
    .out_azimuth (out_azimuth),
    .out_lat     (out_lat),
    .out_lon     (out_lon),
    .out_vel     (out_vel),
    .out_vel_err (out_vel_err),
    .out_pwr     (out_pwr),
    .out_pwr_err (out_pwr_err),
    .out_wdt     (out_wdt),
    .out_wdt_err (out_wdt_err),
    .out_last    (out_last)
  );

  // An accepted vector keeps the block busy in the cycle after it is taken.
  `GIVM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // A result is never loaded over one that is still held by the consumer.
  `GIVM_ASSERT_SAME(a_no_overwrite, cmd.load_out, !out_valid || !out_stall)
  // The divider is quiet whenever the block can take a new vector.
  `GIVM_ASSERT_SAME(a_idle_div_quiet, !in_stall, !sts.div_busy)

endmodule
